FILE: src/bmp_pixel_unpacker_assert.svh
// assertion macros shared by the bmp pixel unpacker modules
`ifndef BMP_PIXEL_UNPACKER_ASSERT_SVH
`define BMP_PIXEL_UNPACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BPU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BPU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BPU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define BPU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: src/bpu_pkg.sv
// types and constants shared by the bmp pixel unpacker modules
package bpu_pkg;

   localparam int COORD_W     = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_FORMAT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_DOWN     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WANT_ALPHA   = 3'd4;

   // pixel formats
   localparam logic [2:0] FMT_1BPP  = 3'd0;
   localparam logic [2:0] FMT_4BPP  = 3'd1;
   localparam logic [2:0] FMT_8BPP  = 3'd2;
   localparam logic [2:0] FMT_24BPP = 3'd3;
   localparam logic [2:0] FMT_32BPP = 3'd4;

   // commands
   localparam logic CMD_PALETTE = 1'b0;
   localparam logic CMD_PIXEL   = 1'b1;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

   localparam logic [2:0]  RST_PIXEL_FORMAT = FMT_24BPP;
   localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd1;
   localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd1;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
      logic [7:0] palette_index;
      logic [7:0] palette_blue;
      logic [7:0] palette_green;
      logic [7:0] palette_red;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]         blue;
      logic [7:0]         green;
      logic [7:0]         red;
      logic [7:0]         alpha;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] dest_row;
      logic               last;
      logic               image_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0]  pixel_format;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic        top_down;
      logic        want_alpha;
   } cfg_type;

   typedef struct packed {
      logic        en;
      logic [7:0]  index;
      logic [23:0] rgb;
   } pal_wr_type;

   typedef struct packed {
      logic               direct;
      logic [23:0]        rgb;
      logic [7:0]         alpha;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] dest_row;
      logic               last;
      logic               image_done;
   } pix_desc_type;

endpackage

FILE: src/bpu_ram.sv
// generic single-write, single-read ram with registered read data
module bpu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bpu_palette.sv
// colour table: ram plus per-entry valid bits so unwritten entries read as black
`include "bmp_pixel_unpacker_assert.svh"
module bpu_palette #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  bpu_pkg::pal_wr_type wr,
   input  logic                rd_en,
   input  logic [7:0]          rd_index,
   output logic [23:0]         rd_rgb,
   output logic                rd_hit
);

   localparam int AW = $clog2(PALETTE_DEPTH);

   logic [PALETTE_DEPTH-1:0] valid_ff, valid_in;
   logic                     hit_ff, hit_in;
   logic                     wr_ok, rd_ok;
   logic [AW-1:0]            wr_addr, rd_addr;

   always_comb begin
      wr_ok    = wr.en && (32'(wr.index) < 32'(PALETTE_DEPTH));
      rd_ok    = 32'(rd_index) < 32'(PALETTE_DEPTH);
      wr_addr  = wr.index[AW-1:0];
      rd_addr  = rd_index[AW-1:0];
      valid_in = valid_ff;
      if (wr_ok) begin
         valid_in[wr_addr] = 1'b1;
      end
      hit_in = rd_en ? (rd_ok && valid_ff[rd_addr]) : hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end

   bpu_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (wr_addr),
      .wr_data (wr.rgb),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_rgb)
   );

   assign rd_hit = hit_ff;

   `BPU_ASSERT_NEXT(a_write_marks_valid, clock, reset, wr_ok, valid_ff[$past(wr_addr)], "palette write did not set its valid bit")

endmodule

FILE: src/bpu_unpack.sv
// input register and byte sequencer: row/column tracking and one pixel out per cycle while pix_ready is high
`include "bmp_pixel_unpacker_assert.svh"
module bpu_unpack #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bpu_pkg::cfg_type         cfg,
   input  logic                     restart,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  bpu_pkg::req_payload_type req_payload,
   input  logic                     pix_ready,
   output logic                     pix_valid,
   output bpu_pkg::pix_desc_type    pix_desc,
   output logic [7:0]               pal_rd_index,
   output bpu_pkg::pal_wr_type      pal_wr
);

   localparam int W_W   = $clog2(MAX_WIDTH + 1);
   localparam int H_W   = $clog2(MAX_HEIGHT + 1);
   localparam int RB_W  = W_W + 2;
   localparam int COL_W = bpu_pkg::COORD_W;

   logic                     s1_valid_ff, s1_valid_in;
   bpu_pkg::req_payload_type item_ff, item_in;
   logic [RB_W-1:0]          rb_cnt_ff, rb_cnt_in;
   logic [W_W-1:0]           col_ff, col_in;
   logic [H_W-1:0]           row_ff, row_in;
   logic [23:0]              part_ff, part_in;
   logic [1:0]               ccnt_ff, ccnt_in;
   logic [2:0]               sub_ff, sub_in;

   logic [W_W-1:0]  eff_w;
   logic [H_W-1:0]  eff_h;
   logic [H_W-1:0]  drow;
   logic [RB_W-1:0] data_bytes, pad_sum, stride, rb_next;
   logic [2:0]      last_sub;
   logic [7:0]      b;
   logic fmt_ok, is_pixel, is_load, active, in_data, col_ok, col_is_end;
   logic produces, emit, emit_last, finish, byte_end, accept, direct, is_32;

   always_comb begin
      eff_w = (32'(cfg.image_width) > 32'(MAX_WIDTH)) ? W_W'(MAX_WIDTH) : W_W'(cfg.image_width);
      eff_h = (32'(cfg.image_height) > 32'(MAX_HEIGHT)) ?
              H_W'(MAX_HEIGHT) : H_W'(cfg.image_height);

      case (cfg.pixel_format)
         bpu_pkg::FMT_1BPP:  data_bytes = (RB_W'(eff_w) + RB_W'(7)) >> 3;
         bpu_pkg::FMT_4BPP:  data_bytes = (RB_W'(eff_w) + RB_W'(1)) >> 1;
         bpu_pkg::FMT_8BPP:  data_bytes = RB_W'(eff_w);
         bpu_pkg::FMT_24BPP: data_bytes = (RB_W'(eff_w) << 1) + RB_W'(eff_w);
         default:            data_bytes = RB_W'(eff_w) << 2;
      endcase
      // rows are padded to a multiple of 4 bytes
      pad_sum = data_bytes + RB_W'(3);
      stride  = {pad_sum[RB_W-1:2], 2'b00};

      b          = item_ff.data_byte;
      fmt_ok     = cfg.pixel_format <= bpu_pkg::FMT_32BPP;
      is_32      = cfg.pixel_format == bpu_pkg::FMT_32BPP;
      direct     = (cfg.pixel_format == bpu_pkg::FMT_24BPP) || is_32;
      is_pixel   = s1_valid_ff && (item_ff.command == bpu_pkg::CMD_PIXEL);
      is_load    = s1_valid_ff && (item_ff.command == bpu_pkg::CMD_PALETTE);
      active     = is_pixel && fmt_ok && (eff_w != '0) && (eff_h != '0) && (row_ff < eff_h);
      in_data    = rb_cnt_ff < data_bytes;
      col_ok     = col_ff < eff_w;
      col_is_end = col_ff == (eff_w - W_W'(1));

      case (cfg.pixel_format)
         bpu_pkg::FMT_1BPP: begin
            produces = 1'b1;
            last_sub = 3'd7;
         end
         bpu_pkg::FMT_4BPP: begin
            produces = 1'b1;
            last_sub = 3'd1;
         end
         bpu_pkg::FMT_8BPP: begin
            produces = 1'b1;
            last_sub = 3'd0;
         end
         bpu_pkg::FMT_24BPP: begin
            produces = ccnt_ff == 2'd2;
            last_sub = 3'd0;
         end
         default: begin
            produces = ccnt_ff == 2'd3;
            last_sub = 3'd0;
         end
      endcase

      emit      = active && in_data && col_ok && produces;
      // byte is done after this pixel when its sub-pixels run out or the row ends
      emit_last = (sub_ff == last_sub) || col_is_end;
      finish    = s1_valid_ff && (!emit || (pix_ready && emit_last));
      byte_end  = finish && active;
      req_stall = s1_valid_ff && !finish;
      accept    = req_valid && !req_stall;

      case (cfg.pixel_format)
         bpu_pkg::FMT_1BPP: pal_rd_index = {7'd0, b[3'd7 - sub_ff]};
         bpu_pkg::FMT_4BPP: pal_rd_index = {4'd0, (sub_ff[0] ? b[3:0] : b[7:4])};
         default:           pal_rd_index = b;
      endcase

      drow = cfg.top_down ? row_ff : (eff_h - H_W'(1) - row_ff);

      pix_valid           = emit;
      pix_desc.direct     = direct;
      pix_desc.rgb        = is_32 ? part_ff : {b, part_ff[15:0]};
      if (is_32) begin
         pix_desc.alpha = cfg.want_alpha ? b : (bpu_pkg::ALPHA_OPAQUE - b);
      end else begin
         pix_desc.alpha = cfg.want_alpha ? bpu_pkg::ALPHA_OPAQUE : bpu_pkg::ALPHA_CLEAR;
      end
      pix_desc.column     = COL_W'(col_ff);
      pix_desc.dest_row   = COL_W'(drow);
      pix_desc.last       = emit_last;
      pix_desc.image_done = col_is_end && (row_ff == (eff_h - H_W'(1)));

      pal_wr.en    = is_load;
      pal_wr.index = item_ff.palette_index;
      pal_wr.rgb   = {item_ff.palette_red, item_ff.palette_green, item_ff.palette_blue};
   end

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (finish ? 1'b0 : s1_valid_ff);
      item_in     = accept ? req_payload : item_ff;
      rb_cnt_in   = rb_cnt_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      part_in     = part_ff;
      ccnt_in     = ccnt_ff;
      sub_in      = sub_ff;
      rb_next     = rb_cnt_ff + RB_W'(1);

      if (emit && pix_ready) begin
         col_in = col_ff + W_W'(1);
         sub_in = sub_ff + 3'd1;
      end
      if (finish) begin
         sub_in = '0;
      end
      if (byte_end) begin
         if (in_data && direct) begin
            if (produces) begin
               part_in = '0;
               ccnt_in = '0;
            end else begin
               case (ccnt_ff)
                  2'd0:    part_in[7:0]   = b;
                  2'd1:    part_in[15:8]  = b;
                  default: part_in[23:16] = b;
               endcase
               ccnt_in = ccnt_ff + 2'd1;
            end
         end
         if (rb_next >= stride) begin
            rb_cnt_in = '0;
            col_in    = '0;
            part_in   = '0;
            ccnt_in   = '0;
            row_in    = row_ff + H_W'(1);
         end else begin
            rb_cnt_in = rb_next;
         end
      end
      if (restart) begin
         rb_cnt_in = '0;
         col_in    = '0;
         row_in    = '0;
         part_in   = '0;
         ccnt_in   = '0;
         sub_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rb_cnt_ff   <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         part_ff     <= '0;
         ccnt_ff     <= '0;
         sub_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rb_cnt_ff   <= rb_cnt_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         part_ff     <= part_in;
         ccnt_ff     <= ccnt_in;
         sub_ff      <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   `BPU_ASSERT_IMPLY(a_sub_only_mid_byte, clock, reset, sub_ff != 3'd0, is_pixel, "sub-pixel index left over with no byte in progress")
   `BPU_ASSERT_IMPLY(a_row_in_bounds, clock, reset, 1'b1, row_ff <= eff_h, "source row ran past the image height")

endmodule

FILE: src/bmp_pixel_unpacker.sv
// top level of the bmp pixel unpacker: registers, palette and result stage
//
// Takes pixel-array bytes (and palette load transactions) of an uncompressed bmp and
// returns one BGRA pixel per result transaction with its destination column and row.
// A byte or palette load is taken every cycle for 8, 24 and 32 bpp unless stalled; a
// 1 or 4 bpp byte holds the input register until its pixels are out, as the byte
// sequencer hands out one pixel per cycle, stalls apart, to the palette ram read port.
// Results pass through the input register and then the result register, which also
// holds the registered palette read. The 256-entry palette needs no clearing pass:
// per-entry valid bits cleared by reset make unloaded entries read as black. A write
// to any defined register restarts the stream at row 0, column 0.
`include "bmp_pixel_unpacker_assert.svh"
module bmp_pixel_unpacker #(
   parameter int MAX_WIDTH     = 4096,
   parameter int MAX_HEIGHT    = 4096,
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  bpu_pkg::req_payload_type             req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bpu_pkg::rsp_payload_type             rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bpu_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bpu_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   bpu_pkg::cfg_type      cfg_ff, cfg_in;
   bpu_pkg::pix_desc_type pix_desc, desc_ff, desc_in;
   bpu_pkg::pal_wr_type   pal_wr;
   logic                  cfg_restart;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  s2_ready, pix_valid, pal_hit;
   logic [7:0]            pal_rd_index;
   logic [23:0]           pal_rgb, colour;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in      = cfg_ff;
      cfg_restart = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bpu_pkg::CSR_PIXEL_FORMAT: begin
               cfg_in.pixel_format = csr_wdata[2:0];
               cfg_restart         = 1'b1;
            end
            bpu_pkg::CSR_IMAGE_WIDTH: begin
               cfg_in.image_width = csr_wdata;
               cfg_restart        = 1'b1;
            end
            bpu_pkg::CSR_IMAGE_HEIGHT: begin
               cfg_in.image_height = csr_wdata;
               cfg_restart         = 1'b1;
            end
            bpu_pkg::CSR_TOP_DOWN: begin
               cfg_in.top_down = csr_wdata[0];
               cfg_restart     = 1'b1;
            end
            bpu_pkg::CSR_WANT_ALPHA: begin
               cfg_in.want_alpha = csr_wdata[0];
               cfg_restart       = 1'b1;
            end
            default: begin
               cfg_restart = 1'b0;
            end
         endcase
      end
   end

   bpu_unpack #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_unpack (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .restart      (cfg_restart),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .pix_ready    (s2_ready),
      .pix_valid    (pix_valid),
      .pix_desc     (pix_desc),
      .pal_rd_index (pal_rd_index),
      .pal_wr       (pal_wr)
   );

   // result register; the palette ram output register moves in step with it
   always_comb begin
      s2_ready     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = s2_ready ? pix_valid : rsp_valid_ff;
      desc_in      = s2_ready ? pix_desc : desc_ff;
   end

   bpu_palette #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr       (pal_wr),
      .rd_en    (s2_ready),
      .rd_index (pal_rd_index),
      .rd_rgb   (pal_rgb),
      .rd_hit   (pal_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format <= bpu_pkg::RST_PIXEL_FORMAT;
         cfg_ff.image_width  <= bpu_pkg::RST_IMAGE_WIDTH;
         cfg_ff.image_height <= bpu_pkg::RST_IMAGE_HEIGHT;
         cfg_ff.top_down     <= 1'b0;
         cfg_ff.want_alpha   <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

   always_comb begin
      colour = desc_ff.direct ? desc_ff.rgb : (pal_hit ? pal_rgb : 24'd0);
      rsp_payload.blue       = colour[7:0];
      rsp_payload.green      = colour[15:8];
      rsp_payload.red        = colour[23:16];
      rsp_payload.alpha      = desc_ff.alpha;
      rsp_payload.column     = desc_ff.column;
      rsp_payload.dest_row   = desc_ff.dest_row;
      rsp_payload.last       = desc_ff.last;
      rsp_payload.image_done = desc_ff.image_done;
   end

   assign rsp_valid = rsp_valid_ff;

   `BPU_ASSERT_IMPLY(a_done_is_last, clock, reset, rsp_valid_ff && rsp_payload.image_done, rsp_payload.last, "final image pixel not marked last of its byte")
   `BPU_ASSERT_NEXT(a_pixel_waits, clock, reset, pix_valid && !s2_ready && !cfg_restart, pix_valid, "pending pixel dropped while result stage was full")

endmodule

FILE: tb/tb_bmp_pixel_unpacker.sv
// testbench for bmp_pixel_unpacker: directed table, then random images checked by a pixel predictor
module tb_bmp_pixel_unpacker;
   timeunit 1ns;
   timeprecision 1ps;
   import bpu_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned WIDTH_CAP     = 4096;
   localparam int unsigned HEIGHT_CAP    = 4096;
   localparam int unsigned RANDOM_ITEMS  = 120;
   localparam int unsigned MIN_PHASES    = 4;
   localparam logic [CSR_DATA_W-1:0]  REG_MAX     = 13'h1fff;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED  = 3'd7;
   localparam logic [2:0]             FMT_UNKNOWN = 3'd7;

   typedef struct {
      bit                     is_reg;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_value;
      req_payload_type        item;
      bit                     typed;
      rsp_payload_type        want;
   } step_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bmp_pixel_unpacker DUT (.*);

   // predictor copy of configuration and stream state
   logic [2:0]  model_format;
   logic [12:0] model_width;
   logic [12:0] model_height;
   logic        model_top_down;
   logic        model_want_alpha;
   logic [23:0] pal_copy [256];
   int unsigned row_pos;
   int unsigned next_col;
   int unsigned src_row;
   int unsigned color_bytes;
   logic [23:0] color_acc;

   rsp_payload_type pixel_burst[$];
   rsp_payload_type pixel_expect_q[$];
   rsp_payload_type seen_want;

   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;
   int unsigned rsp_hold    = 0;
   bit          calm        = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void restart_row_state();
      row_pos     = 0;
      next_col    = 0;
      src_row     = 0;
      color_bytes = 0;
      color_acc   = '0;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_PIXEL_FORMAT: model_format     = val[2:0];
         CSR_IMAGE_WIDTH:  model_width      = val;
         CSR_IMAGE_HEIGHT: model_height     = val;
         CSR_TOP_DOWN:     model_top_down   = val[0];
         CSR_WANT_ALPHA:   model_want_alpha = val[0];
         default:          return;
      endcase
      restart_row_state();
   endfunction

   function automatic void push_pixel(input logic [23:0] rgb, input logic [7:0] a,
                                      input int unsigned w, input int unsigned h);
      rsp_payload_type px;
      int unsigned     drow;
      drow          = model_top_down ? src_row : h - 1 - src_row;
      px.blue       = rgb[7:0];
      px.green      = rgb[15:8];
      px.red        = rgb[23:16];
      px.alpha      = a;
      px.column     = next_col[COORD_W-1:0];
      px.dest_row   = drow[COORD_W-1:0];
      px.last       = 1'b0;
      px.image_done = (next_col == w - 1) && (src_row == h - 1);
      next_col++;
      pixel_burst.push_back(px);
   endfunction

   // fills pixel_burst with the pixels one transaction causes; returns 0 when ignored
   function automatic bit predict_pixels(input req_payload_type item);
      int unsigned     w;
      int unsigned     h;
      int unsigned     data_bytes;
      int unsigned     stride;
      logic [7:0]      b;
      logic [7:0]      alpha_base;
      rsp_payload_type tail;
      pixel_burst.delete();
      w          = (model_width > WIDTH_CAP) ? WIDTH_CAP : model_width;
      h          = (model_height > HEIGHT_CAP) ? HEIGHT_CAP : model_height;
      b          = item.data_byte;
      alpha_base = model_want_alpha ? ALPHA_OPAQUE : ALPHA_CLEAR;
      if (item.command == CMD_PALETTE) begin
         pal_copy[item.palette_index] = {item.palette_red, item.palette_green,
                                         item.palette_blue};
         return 1'b1;
      end
      if (w == 0 || h == 0 || model_format > FMT_32BPP || src_row >= h)
         return 1'b0;
      case (model_format)
         FMT_1BPP:  data_bytes = (w + 7) >> 3;
         FMT_4BPP:  data_bytes = (w + 1) >> 1;
         FMT_8BPP:  data_bytes = w;
         FMT_24BPP: data_bytes = 3 * w;
         default:   data_bytes = 4 * w;
      endcase
      stride = (data_bytes + 3) & ~(32'd3);
      if (row_pos < data_bytes) begin
         case (model_format)
            FMT_1BPP: begin
               for (int i = 7; i >= 0; i--)
                  if (next_col < w) push_pixel(pal_copy[b[i]], alpha_base, w, h);
            end
            FMT_4BPP: begin
               if (next_col < w) push_pixel(pal_copy[b[7:4]], alpha_base, w, h);
               if (next_col < w) push_pixel(pal_copy[b[3:0]], alpha_base, w, h);
            end
            FMT_8BPP: begin
               if (next_col < w) push_pixel(pal_copy[b], alpha_base, w, h);
            end
            FMT_24BPP: begin
               color_acc = color_acc | (24'(b) << (8 * color_bytes));
               color_bytes++;
               if (color_bytes == 3) begin
                  if (next_col < w) push_pixel(color_acc, alpha_base, w, h);
                  color_acc   = '0;
                  color_bytes = 0;
               end
            end
            default: begin
               // fourth byte of a 32 bpp pixel carries the alpha
               if (color_bytes == 3) begin
                  if (next_col < w)
                     push_pixel(color_acc, model_want_alpha ? b : 8'(ALPHA_OPAQUE - b), w, h);
                  color_acc   = '0;
                  color_bytes = 0;
               end else begin
                  color_acc = color_acc | (24'(b) << (8 * color_bytes));
                  color_bytes++;
               end
            end
         endcase
      end
      row_pos++;
      if (row_pos >= stride) begin
         row_pos     = 0;
         next_col    = 0;
         color_bytes = 0;
         color_acc   = '0;
         src_row++;
      end
      if (pixel_burst.size() != 0) begin
         tail      = pixel_burst.pop_back();
         tail.last = 1'b1;
         pixel_burst.push_back(tail);
      end
      return 1'b1;
   endfunction

   function automatic step_row_type blank_step();
      step_row_type s;
      s.is_reg    = 1'b0;
      s.reg_index = '0;
      s.reg_value = '0;
      s.item      = '0;
      s.typed     = 1'b0;
      s.want      = '0;
      return s;
   endfunction

   function automatic step_row_type reg_step(input logic [CSR_INDEX_W-1:0] idx,
                                             input logic [CSR_DATA_W-1:0] val);
      step_row_type s;
      s           = blank_step();
      s.is_reg    = 1'b1;
      s.reg_index = idx;
      s.reg_value = val;
      return s;
   endfunction

   function automatic step_row_type byte_step(input logic [7:0] b);
      step_row_type s;
      s                = blank_step();
      s.item.command   = CMD_PIXEL;
      s.item.data_byte = b;
      return s;
   endfunction

   function automatic step_row_type load_step(input logic [7:0] idx, input logic [7:0] blue,
                                              input logic [7:0] green, input logic [7:0] red);
      step_row_type s;
      s                    = blank_step();
      s.item.command       = CMD_PALETTE;
      s.item.palette_index = idx;
      s.item.palette_blue  = blue;
      s.item.palette_green = green;
      s.item.palette_red   = red;
      return s;
   endfunction

   function automatic step_row_type known_step(input logic [7:0] b,
                                               input rsp_payload_type px);
      step_row_type s;
      s       = byte_step(b);
      s.typed = 1'b1;
      s.want  = px;
      return s;
   endfunction

   function automatic rsp_payload_type pixel_of(input logic [7:0] b, input logic [7:0] g,
                                                input logic [7:0] r, input logic [7:0] a,
                                                input logic [COORD_W-1:0] col,
                                                input logic [COORD_W-1:0] row,
                                                input logic done);
      rsp_payload_type px;
      px.blue       = b;
      px.green      = g;
      px.red        = r;
      px.alpha      = a;
      px.column     = col;
      px.dest_row   = row;
      px.last       = 1'b1;
      px.image_done = done;
      return px;
   endfunction

   function automatic req_payload_type random_load();
      req_payload_type item;
      item               = req_payload_type'({$urandom, $urandom});
      item.command       = CMD_PALETTE;
      // low entries matter most for 1 and 4 bpp
      if ($urandom_range(0, 1) == 0) item.palette_index = 8'($urandom_range(0, 15));
      return item;
   endfunction

   function automatic req_payload_type random_byte();
      req_payload_type item;
      item         = req_payload_type'({$urandom, $urandom});
      item.command = CMD_PIXEL;
      return item;
   endfunction

   // lowers valid and waits until every predicted pixel has come back
   task automatic drain_pixels();
      req_valid <= 1'b0;
      do @(negedge clock); while (pixel_expect_q.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      drain_pixels();
      // palette loads and padding bytes may still be in flight without any pixel
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // starts and ends at a falling edge; the caller drives valid again at that same edge
   task automatic send_item(input req_payload_type item, input bit typed,
                            input rsp_payload_type typed_pixel, output bit live);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      live = predict_pixels(item);
      if (typed) pixel_expect_q.push_back(typed_pixel);
      else foreach (pixel_burst[k]) pixel_expect_q.push_back(pixel_burst[k]);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // result checker; also counts down the stall cycles drawn for each result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_expect_q.size() == 0) begin
            $error("pixel transaction with nothing expected: %p", rsp_payload);
            fail_count++;
         end else begin
            seen_want = pixel_expect_q.pop_front();
            check_field("blue", 32'(seen_want.blue), 32'(rsp_payload.blue));
            check_field("green", 32'(seen_want.green), 32'(rsp_payload.green));
            check_field("red", 32'(seen_want.red), 32'(rsp_payload.red));
            check_field("alpha", 32'(seen_want.alpha), 32'(rsp_payload.alpha));
            check_field("column", 32'(seen_want.column), 32'(rsp_payload.column));
            check_field("dest_row", 32'(seen_want.dest_row), 32'(rsp_payload.dest_row));
            check_field("last", 32'(seen_want.last), 32'(rsp_payload.last));
            check_field("image_done", 32'(seen_want.image_done),
                        32'(rsp_payload.image_done));
         end
         rsp_hold = calm ? 0 : $urandom_range(0, 15);
      end else if (rsp_hold != 0) begin
         rsp_hold--;
      end
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= (rsp_hold != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      step_row_type plan[$];
      int unsigned  phase;
      int unsigned  counted;
      int unsigned  sent;
      int unsigned  cap;
      int unsigned  pick;
      int unsigned  h_eff;
      logic [2:0]   fmt;
      logic [12:0]  wide;
      logic [12:0]  tall;
      bit           live;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      model_format     = RST_PIXEL_FORMAT;
      model_width      = RST_IMAGE_WIDTH;
      model_height     = RST_IMAGE_HEIGHT;
      model_top_down   = 1'b0;
      model_want_alpha = 1'b0;
      foreach (pal_copy[k]) pal_copy[k] = '0;
      restart_row_state();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // reset state: 24 bpp, 1x1, bottom-up, alpha clear
      plan.push_back(byte_step(8'h00));
      plan.push_back(byte_step(8'hff));
      plan.push_back(known_step(8'h80, pixel_of(8'h00, 8'hff, 8'h80, ALPHA_CLEAR, 12'd0, 12'd0,
                                                1'b1)));
      plan.push_back(byte_step(8'h5a));   // row padding
      plan.push_back(byte_step(8'ha5));   // past the last row
      plan.push_back(reg_step(CSR_PIXEL_FORMAT, 13'(FMT_32BPP)));
      plan.push_back(byte_step(8'h12));
      plan.push_back(byte_step(8'h34));
      plan.push_back(byte_step(8'h56));
      plan.push_back(known_step(8'h00, pixel_of(8'h12, 8'h34, 8'h56, ALPHA_OPAQUE, 12'd0, 12'd0,
                                                1'b1)));
      plan.push_back(load_step(8'h01, 8'hff, 8'h00, 8'h80));
      plan.push_back(load_step(8'hff, 8'hff, 8'hff, 8'hff));
      plan.push_back(load_step(8'h0f, 8'h01, 8'h02, 8'h03));
      // 1 bpp, 3 wide, two rows: partial byte and mirroring
      plan.push_back(reg_step(CSR_PIXEL_FORMAT, 13'(FMT_1BPP)));
      plan.push_back(reg_step(CSR_IMAGE_WIDTH, 13'd3));
      plan.push_back(reg_step(CSR_IMAGE_HEIGHT, 13'd2));
      plan.push_back(byte_step(8'ha0));
      plan.push_back(byte_step(8'hff));
      plan.push_back(byte_step(8'hff));
      plan.push_back(byte_step(8'hff));
      plan.push_back(byte_step(8'h5f));
      // 4 bpp odd width: low nibble of the last data byte is dropped
      plan.push_back(reg_step(CSR_PIXEL_FORMAT, 13'(FMT_4BPP)));
      plan.push_back(reg_step(CSR_IMAGE_HEIGHT, 13'd1));
      plan.push_back(byte_step(8'h1f));
      plan.push_back(byte_step(8'hf0));
      plan.push_back(reg_step(CSR_WANT_ALPHA, 13'd1));
      plan.push_back(reg_step(CSR_PIXEL_FORMAT, 13'(FMT_8BPP)));
      plan.push_back(reg_step(CSR_IMAGE_WIDTH, 13'd1));
      plan.push_back(known_step(8'hff, pixel_of(8'hff, 8'hff, 8'hff, ALPHA_OPAQUE, 12'd0, 12'd0,
                                                1'b1)));
      plan.push_back(reg_step(CSR_PIXEL_FORMAT, 13'(FMT_UNKNOWN)));
      plan.push_back(byte_step(8'h3c));
      plan.push_back(reg_step(CSR_PIXEL_FORMAT, 13'(FMT_8BPP)));
      plan.push_back(reg_step(CSR_IMAGE_WIDTH, 13'd0));
      plan.push_back(byte_step(8'h3c));
      // oversized dimensions clamp to the maximum
      plan.push_back(reg_step(CSR_IMAGE_WIDTH, REG_MAX));
      plan.push_back(reg_step(CSR_IMAGE_HEIGHT, REG_MAX));
      plan.push_back(known_step(8'h0f, pixel_of(8'h01, 8'h02, 8'h03, ALPHA_OPAQUE, 12'd0,
                                                12'hfff, 1'b0)));
      plan.push_back(reg_step(CSR_TOP_DOWN, 13'd1));
      plan.push_back(byte_step(8'h01));
      plan.push_back(reg_step(CSR_UNUSED, REG_MAX));   // no register, no restart
      plan.push_back(byte_step(8'h00));

      foreach (plan[k]) begin
         if (plan[k].is_reg) write_reg(plan[k].reg_index, plan[k].reg_value);
         else send_item(plan[k].item, plan[k].typed, plan[k].want, live);
      end

      phase   = 0;
      counted = 0;
      while (counted < RANDOM_ITEMS || phase < MIN_PHASES) begin
         calm = ($urandom_range(0, 4) == 0);
         fmt  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(FMT_32BPP + 1, FMT_UNKNOWN))
                                             : 3'($urandom_range(FMT_1BPP, FMT_32BPP));
         pick = $urandom_range(0, 15);
         if (pick == 0) wide = '0;
         else if (pick == 1) wide = 13'($urandom_range(WIDTH_CAP - 2, REG_MAX));
         else wide = 13'($urandom_range(1, 10));
         pick = $urandom_range(0, 15);
         if (pick == 0) tall = '0;
         else if (pick == 1) tall = 13'($urandom_range(HEIGHT_CAP - 2, REG_MAX));
         else tall = 13'($urandom_range(1, 3));
         h_eff = (tall > HEIGHT_CAP) ? HEIGHT_CAP : tall;

         // upper data bits beyond each register's width are don't-care
         write_reg(CSR_PIXEL_FORMAT, {10'($urandom), fmt});
         write_reg(CSR_IMAGE_WIDTH, wide);
         write_reg(CSR_IMAGE_HEIGHT, tall);
         write_reg(CSR_TOP_DOWN, 13'($urandom));
         write_reg(CSR_WANT_ALPHA, 13'($urandom));

         repeat ($urandom_range(0, 4)) send_item(random_load(), 1'b0, '0, live);

         if (wide == 0 || tall == 0 || fmt > FMT_32BPP) cap = $urandom_range(4, 12);
         else cap = $urandom_range(24, 96);
         sent = 0;
         while (src_row < h_eff && sent < cap) begin
            if (sent == 2 && (phase == 0 || $urandom_range(0, 7) == 0)) drain_pixels();
            if ($urandom_range(0, 15) == 0) send_item(random_load(), 1'b0, '0, live);
            send_item(random_byte(), 1'b0, '0, live);
            if (live) counted++;
            sent++;
         end
         // trailing bytes past the image
         repeat ($urandom_range(0, 3)) send_item(random_byte(), 1'b0, '0, live);
         phase++;
      end

      calm = 1'b0;
      drain_pixels();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
